// ----- src/rotation_matrix_to_quaternion_core_macros.svh -----
// Assertion macros for the rotation matrix to quaternion core checker.
// Depends on nothing; included by the checker file only.
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define RMQ_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("rmq checker: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define RMQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rmq checker: implication violated");

`endif

// ----- src/rmq_pkg.sv -----
// Shared types, defaults and width helpers for the rotation matrix to quaternion core.
// Depends on nothing; imported by every module of the core and by its checker.
`timescale 1ns / 1ps

package rmq_pkg;

   localparam int VALUE_WIDTH_DEF   = 16;
   localparam int FRACTION_BITS_DEF = 14;

   // Branch that picks the main quaternion component
   typedef enum logic [1:0] {
      SEL_X     = 2'd0,
      SEL_Y     = 2'd1,
      SEL_Z     = 2'd2,
      SEL_TRACE = 2'd3
   } sel_type;

   // Control that travels with each beat down the pipeline
   typedef struct packed {
      logic    valid;
      sel_type sel;
      logic    clamped;
   } rmq_ctl_type;

   // Signed width of the radicand: diagonal sums plus one
   function automatic int rmq_rad_width(input int vw, input int fb);
      return ((vw > fb + 2) ? vw : fb + 2) + 3;
   endfunction

   // Bits of the half square root (one pipeline stage per bit)
   function automatic int rmq_root_width(input int vw, input int fb);
      int xw;
      xw = rmq_rad_width(vw, fb) - 1 + fb - 2;
      return (xw + 1) >> 1;
   endfunction

   // Bits of the divider numerator and quotient (one stage per bit)
   function automatic int rmq_quot_width(input int vw, input int fb);
      return vw + fb + 2;
   endfunction

   // Start-to-strobe latency in clock cycles
   function automatic int rmq_latency(input int vw, input int fb);
      return 3 + rmq_root_width(vw, fb) + rmq_quot_width(vw, fb);
   endfunction

endpackage

// ----- src/rotation_matrix_to_quaternion_core.sv -----
// Rotation matrix to unit quaternion converter, trace method. Takes one matrix per clock
// cycle: a beat is accepted when start is high and busy is low, and busy is high only
// while reset is asserted. The result appears on the rsp_ ports for exactly one cycle,
// marked by rsp_valid. A beat passes the front end, the square root (one root bit per
// stage; RB, the root width, is ceil((rad width - 1 + FRACTION_BITS - 2) / 2), 15 at the
// defaults), the three-lane divider (one quotient bit per stage; NW = VALUE_WIDTH +
// FRACTION_BITS + 2, 32 at the defaults) and the output register. The receiver cannot
// stall the result; results leave in start order.
// Depends on rmq_pkg, rmq_front, rmq_sqrt and rmq_div.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_core
   import rmq_pkg::*;
#(
   parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [VALUE_WIDTH-1:0]  req_r00,
   input  logic [VALUE_WIDTH-1:0]  req_r01,
   input  logic [VALUE_WIDTH-1:0]  req_r02,
   input  logic [VALUE_WIDTH-1:0]  req_r10,
   input  logic [VALUE_WIDTH-1:0]  req_r11,
   input  logic [VALUE_WIDTH-1:0]  req_r12,
   input  logic [VALUE_WIDTH-1:0]  req_r20,
   input  logic [VALUE_WIDTH-1:0]  req_r21,
   input  logic [VALUE_WIDTH-1:0]  req_r22,
   output logic                    rsp_valid,
   output logic [VALUE_WIDTH-1:0]  rsp_quat_scalar,
   output logic [VALUE_WIDTH-1:0]  rsp_quat_x,
   output logic [VALUE_WIDTH-1:0]  rsp_quat_y,
   output logic [VALUE_WIDTH-1:0]  rsp_quat_z,
   output logic                    rsp_radicand_clamped
);

   localparam int W    = VALUE_WIDTH;
   localparam int DW   = W + 1;
   localparam int RADW = rmq_rad_width(VALUE_WIDTH, FRACTION_BITS);
   localparam int RB   = rmq_root_width(VALUE_WIDTH, FRACTION_BITS);
   localparam int NW   = rmq_quot_width(VALUE_WIDTH, FRACTION_BITS);
   localparam logic [NW-1:0] POS_LIM = NW'((64'd1 << (W - 1)) - 64'd1);
   localparam logic [NW-1:0] NEG_LIM = NW'(64'd1 << (W - 1));
   localparam logic [W-1:0]  VMAX    = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  VMIN    = {1'b1, {(W-1){1'b0}}};

   // Hold off beats only while in reset
   assign busy = reset;

   rmq_ctl_type          fr_ctl, sq_ctl, dv_ctl;
   logic [RADW-2:0]      fr_rad;
   logic [2:0][DW-1:0]   fr_diff, sq_diff;
   logic [RB-1:0]        sq_root, dv_half;
   logic [2:0][NW-1:0]   dv_quot;
   logic [2:0]           dv_neg;

   rmq_front #(
      .VALUE_WIDTH   (VALUE_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .mat      ({req_r22, req_r21, req_r20, req_r12, req_r11, req_r10,
                  req_r02, req_r01, req_r00}),
      .ctl      (fr_ctl),
      .rad      (fr_rad),
      .diff     (fr_diff)
   );

   rmq_sqrt #(
      .VALUE_WIDTH   (VALUE_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .ctl_i  (fr_ctl),
      .rad    (fr_rad),
      .diff_i (fr_diff),
      .ctl_o  (sq_ctl),
      .root   (sq_root),
      .diff_o (sq_diff)
   );

   rmq_div #(
      .VALUE_WIDTH   (VALUE_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .ctl_i  (sq_ctl),
      .half_i (sq_root),
      .diff   (sq_diff),
      .ctl_o  (dv_ctl),
      .half_o (dv_half),
      .quot   (dv_quot),
      .neg    (dv_neg)
   );

   function automatic logic [W-1:0] sat_quot(input logic [NW-1:0] q, input logic n);
      logic [NW-1:0] nq;
      nq = ~q + 1'b1;
      if (n) begin
         return (q > NEG_LIM) ? VMIN : nq[W-1:0];
      end
      return (q > POS_LIM) ? VMAX : q[W-1:0];
   endfunction

   // Saturate and route components by branch
   logic [W-1:0] main_v, c0_v, c1_v, c2_v;
   logic [W-1:0] s_in, x_in, y_in, z_in;

   always_comb begin
      main_v = (NW'(dv_half) > POS_LIM) ? VMAX : W'(dv_half);
      c0_v   = sat_quot(dv_quot[0], dv_neg[0]);
      c1_v   = sat_quot(dv_quot[1], dv_neg[1]);
      c2_v   = sat_quot(dv_quot[2], dv_neg[2]);
      unique case (dv_ctl.sel)
         SEL_TRACE: begin
            s_in = main_v; x_in = c0_v; y_in = c1_v; z_in = c2_v;
         end
         SEL_X: begin
            s_in = c2_v; x_in = main_v; y_in = c0_v; z_in = c1_v;
         end
         SEL_Y: begin
            s_in = c2_v; x_in = c0_v; y_in = main_v; z_in = c1_v;
         end
         default: begin
            s_in = c2_v; x_in = c0_v; y_in = c1_v; z_in = main_v;
         end
      endcase
   end

   logic         valid_ff, clamped_ff;
   logic [W-1:0] s_ff, x_ff, y_ff, z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= dv_ctl.valid;
      end
      clamped_ff <= dv_ctl.clamped;
      s_ff       <= s_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
   end

   assign rsp_valid            = valid_ff;
   assign rsp_quat_scalar      = s_ff;
   assign rsp_quat_x           = x_ff;
   assign rsp_quat_y           = y_ff;
   assign rsp_quat_z           = z_ff;
   assign rsp_radicand_clamped = clamped_ff;

endmodule

// ----- src/rmq_front.sv -----
// Front end: trace, branch select, radicand with clamp and off-diagonal terms.
// Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_front
   import rmq_pkg::*;
#(
   parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  logic [8:0][VALUE_WIDTH-1:0]            mat,
   output rmq_ctl_type                            ctl,
   output logic [rmq_rad_width(VALUE_WIDTH, FRACTION_BITS)-2:0] rad,
   output logic [2:0][VALUE_WIDTH:0]              diff
);

   localparam int W    = VALUE_WIDTH;
   localparam int TW   = W + 2;
   localparam int DW   = W + 1;
   localparam int RADW = rmq_rad_width(VALUE_WIDTH, FRACTION_BITS);
   localparam logic signed [RADW-1:0] ONE = RADW'(1) << FRACTION_BITS;

   function automatic logic signed [RADW-1:0] ext_r(input logic [W-1:0] v);
      return RADW'($signed(v));
   endfunction

   function automatic logic signed [DW-1:0] ext_d(input logic [W-1:0] v);
      return DW'($signed(v));
   endfunction

   // Stage one: trace sign and branch select
   logic [8:0][W-1:0]     mat_ff;
   sel_type               sel_ff, sel_in;
   logic                  v1_ff;
   logic signed [TW-1:0]  trace_w;
   sel_type               sel_a;
   logic signed [W-1:0]   max_a;

   always_comb begin
      trace_w = TW'($signed(mat[0])) + TW'($signed(mat[4])) + TW'($signed(mat[8]));
      sel_a   = ($signed(mat[4]) > $signed(mat[0])) ? SEL_Y : SEL_X;
      max_a   = (sel_a == SEL_Y) ? $signed(mat[4]) : $signed(mat[0]);
      if (!trace_w[TW-1]) begin
         sel_in = SEL_TRACE;
      end else if ($signed(mat[8]) > max_a) begin
         sel_in = SEL_Z;
      end else begin
         sel_in = sel_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      mat_ff <= mat;
      sel_ff <= sel_in;
   end

   // Stage two: radicand and differences for the chosen branch
   logic signed [RADW-1:0] rad_w;
   logic signed [DW-1:0]   d0_w, d1_w, d2_w;
   logic [RADW-2:0]        rad_in, rad_ff;
   logic                   clamp_in;
   logic [2:0][DW-1:0]     diff_ff;
   rmq_ctl_type            ctl_ff;

   always_comb begin
      unique case (sel_ff)
         SEL_TRACE: begin
            rad_w = ext_r(mat_ff[0]) + ext_r(mat_ff[4]) + ext_r(mat_ff[8]) + ONE;
            d0_w  = ext_d(mat_ff[7]) - ext_d(mat_ff[5]);
            d1_w  = ext_d(mat_ff[2]) - ext_d(mat_ff[6]);
            d2_w  = ext_d(mat_ff[3]) - ext_d(mat_ff[1]);
         end
         SEL_X: begin
            rad_w = ext_r(mat_ff[0]) - (ext_r(mat_ff[4]) + ext_r(mat_ff[8])) + ONE;
            d0_w  = ext_d(mat_ff[1]) + ext_d(mat_ff[3]);
            d1_w  = ext_d(mat_ff[2]) + ext_d(mat_ff[6]);
            d2_w  = ext_d(mat_ff[7]) - ext_d(mat_ff[5]);
         end
         SEL_Y: begin
            rad_w = ext_r(mat_ff[4]) - (ext_r(mat_ff[8]) + ext_r(mat_ff[0])) + ONE;
            d0_w  = ext_d(mat_ff[1]) + ext_d(mat_ff[3]);
            d1_w  = ext_d(mat_ff[5]) + ext_d(mat_ff[7]);
            d2_w  = ext_d(mat_ff[2]) - ext_d(mat_ff[6]);
         end
         default: begin
            rad_w = ext_r(mat_ff[8]) - (ext_r(mat_ff[0]) + ext_r(mat_ff[4])) + ONE;
            d0_w  = ext_d(mat_ff[2]) + ext_d(mat_ff[6]);
            d1_w  = ext_d(mat_ff[5]) + ext_d(mat_ff[7]);
            d2_w  = ext_d(mat_ff[3]) - ext_d(mat_ff[1]);
         end
      endcase
      // clamp a non-positive radicand to the smallest step
      clamp_in = rad_w[RADW-1] || (rad_w == '0);
      rad_in   = clamp_in ? (RADW-1)'(1) : rad_w[RADW-2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= v1_ff;
      end
      ctl_ff.sel     <= sel_ff;
      ctl_ff.clamped <= clamp_in;
      rad_ff         <= rad_in;
      diff_ff        <= {d2_w, d1_w, d0_w};
   end

   assign ctl  = ctl_ff;
   assign rad  = rad_ff;
   assign diff = diff_ff;

endmodule

// ----- src/rmq_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, with side data.
// Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_sqrt
   import rmq_pkg::*;
#(
   parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  rmq_ctl_type                                            ctl_i,
   input  logic [rmq_rad_width(VALUE_WIDTH, FRACTION_BITS)-2:0]   rad,
   input  logic [2:0][VALUE_WIDTH:0]                              diff_i,
   output rmq_ctl_type                                            ctl_o,
   output logic [rmq_root_width(VALUE_WIDTH, FRACTION_BITS)-1:0]  root,
   output logic [2:0][VALUE_WIDTH:0]                              diff_o
);

   localparam int DW   = VALUE_WIDTH + 1;
   localparam int RB   = rmq_root_width(VALUE_WIDTH, FRACTION_BITS);
   localparam int XW   = 2 * RB;

   rmq_ctl_type         ctl_src  [RB];
   rmq_ctl_type         ctl_ff   [RB];
   logic [XW-1:0]       x_src    [RB];
   logic [XW-1:0]       x_ff     [RB];
   logic [RB-1:0]       root_src [RB];
   logic [RB-1:0]       root_in  [RB];
   logic [RB-1:0]       root_ff  [RB];
   logic [RB:0]         rem_src  [RB];
   logic [RB:0]         rem_in   [RB];
   logic [RB:0]         rem_ff   [RB];
   logic [2:0][DW-1:0]  diff_src [RB];
   logic [2:0][DW-1:0]  diff_ff  [RB];

   // Feed the first stage with the scaled radicand
   assign ctl_src[0]  = ctl_i;
   assign x_src[0]    = XW'(rad) << (FRACTION_BITS - 2);
   assign root_src[0] = '0;
   assign rem_src[0]  = '0;
   assign diff_src[0] = diff_i;

   for (genvar s = 0; s < RB; s++) begin : g_stage
      logic [RB+2:0] rem_sh;
      logic [RB+2:0] trial;

      if (s > 0) begin : g_link
         assign ctl_src[s]  = ctl_ff[s-1];
         assign x_src[s]    = x_ff[s-1];
         assign root_src[s] = root_ff[s-1];
         assign rem_src[s]  = rem_ff[s-1];
         assign diff_src[s] = diff_ff[s-1];
      end

      // Bring down two radicand bits and try the next root bit
      always_comb begin
         rem_sh = {rem_src[s], x_src[s][XW-1-2*s -: 2]};
         trial  = {1'b0, root_src[s], 2'b01};
         if (rem_sh >= trial) begin
            rem_in[s]  = (RB+1)'(rem_sh - trial);
            root_in[s] = {root_src[s][RB-2:0], 1'b1};
         end else begin
            rem_in[s]  = rem_sh[RB:0];
            root_in[s] = {root_src[s][RB-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s].valid <= 1'b0;
         end else begin
            ctl_ff[s].valid <= ctl_src[s].valid;
         end
         ctl_ff[s].sel     <= ctl_src[s].sel;
         ctl_ff[s].clamped <= ctl_src[s].clamped;
         x_ff[s]           <= x_src[s];
         root_ff[s]        <= root_in[s];
         rem_ff[s]         <= rem_in[s];
         diff_ff[s]        <= diff_src[s];
      end
   end

   assign ctl_o  = ctl_ff[RB-1];
   assign root   = root_ff[RB-1];
   assign diff_o = diff_ff[RB-1];

endmodule

// ----- src/rmq_div.sv -----
// Pipelined three-lane restoring divider, rounding to nearest, one quotient bit per stage.
// Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_div
   import rmq_pkg::*;
#(
   parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                                                        clock,
   input  logic                                                        reset,
   input  rmq_ctl_type                                                 ctl_i,
   input  logic [rmq_root_width(VALUE_WIDTH, FRACTION_BITS)-1:0]       half_i,
   input  logic [2:0][VALUE_WIDTH:0]                                   diff,
   output rmq_ctl_type                                                 ctl_o,
   output logic [rmq_root_width(VALUE_WIDTH, FRACTION_BITS)-1:0]       half_o,
   output logic [2:0][rmq_quot_width(VALUE_WIDTH, FRACTION_BITS)-1:0]  quot,
   output logic [2:0]                                                  neg
);

   localparam int DW   = VALUE_WIDTH + 1;
   localparam int RB   = rmq_root_width(VALUE_WIDTH, FRACTION_BITS);
   localparam int NW   = rmq_quot_width(VALUE_WIDTH, FRACTION_BITS);
   localparam int DENW = RB + 2;

   rmq_ctl_type           ctl_src  [NW];
   rmq_ctl_type           ctl_ff   [NW];
   logic [RB-1:0]         half_src [NW];
   logic [RB-1:0]         half_ff  [NW];
   logic [2:0]            neg_src  [NW];
   logic [2:0]            neg_ff   [NW];
   logic [2:0][NW-1:0]    num_src  [NW];
   logic [2:0][NW-1:0]    num_ff   [NW];
   logic [2:0][NW-1:0]    q_src    [NW];
   logic [2:0][NW-1:0]    q_in     [NW];
   logic [2:0][NW-1:0]    q_ff     [NW];
   logic [2:0][DENW-1:0]  rem_src  [NW];
   logic [2:0][DENW-1:0]  rem_in   [NW];
   logic [2:0][DENW-1:0]  rem_ff   [NW];

   // Form magnitude * 2^F + den/2 for each lane
   logic [2:0][NW-1:0] num0;
   logic [2:0]         neg0;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic [DW-1:0] mag;
         neg0[k] = diff[k][DW-1];
         mag     = neg0[k] ? DW'(~diff[k] + 1'b1) : diff[k];
         num0[k] = (NW'(mag) << FRACTION_BITS) + NW'({half_i, 1'b0});
      end
   end

   assign ctl_src[0]  = ctl_i;
   assign half_src[0] = half_i;
   assign neg_src[0]  = neg0;
   assign num_src[0]  = num0;
   assign q_src[0]    = '0;
   assign rem_src[0]  = '0;

   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic [DENW-1:0] den;

      if (s > 0) begin : g_link
         assign ctl_src[s]  = ctl_ff[s-1];
         assign half_src[s] = half_ff[s-1];
         assign neg_src[s]  = neg_ff[s-1];
         assign num_src[s]  = num_ff[s-1];
         assign q_src[s]    = q_ff[s-1];
         assign rem_src[s]  = rem_ff[s-1];
      end

      assign den = {half_src[s], 2'b00};

      // Shift in one numerator bit and subtract where it fits
      always_comb begin
         for (int k = 0; k < 3; k++) begin
            logic [DENW:0] rem_sh;
            rem_sh = {rem_src[s][k], num_src[s][k][NW-1]};
            if (rem_sh >= {1'b0, den}) begin
               rem_in[s][k] = DENW'(rem_sh - {1'b0, den});
               q_in[s][k]   = {q_src[s][k][NW-2:0], 1'b1};
            end else begin
               rem_in[s][k] = rem_sh[DENW-1:0];
               q_in[s][k]   = {q_src[s][k][NW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s].valid <= 1'b0;
         end else begin
            ctl_ff[s].valid <= ctl_src[s].valid;
         end
         ctl_ff[s].sel     <= ctl_src[s].sel;
         ctl_ff[s].clamped <= ctl_src[s].clamped;
         half_ff[s]        <= half_src[s];
         neg_ff[s]         <= neg_src[s];
         for (int k = 0; k < 3; k++) begin
            num_ff[s][k] <= num_src[s][k] << 1;
         end
         q_ff[s]   <= q_in[s];
         rem_ff[s] <= rem_in[s];
      end
   end

   assign ctl_o  = ctl_ff[NW-1];
   assign half_o = half_ff[NW-1];
   assign quot   = q_ff[NW-1];
   assign neg    = neg_ff[NW-1];

endmodule

// ----- src/rmq_checker.sv -----
// Port-level checks for the rotation matrix to quaternion core, bound to the top level.
// Depends on rmq_pkg and rotation_matrix_to_quaternion_core_macros.svh.
`timescale 1ns / 1ps
`include "rotation_matrix_to_quaternion_core_macros.svh"

module rmq_checker
   import rmq_pkg::*;
#(
   parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic [VALUE_WIDTH-1:0]  req_r00,
   input logic [VALUE_WIDTH-1:0]  req_r01,
   input logic [VALUE_WIDTH-1:0]  req_r02,
   input logic [VALUE_WIDTH-1:0]  req_r10,
   input logic [VALUE_WIDTH-1:0]  req_r11,
   input logic [VALUE_WIDTH-1:0]  req_r12,
   input logic [VALUE_WIDTH-1:0]  req_r20,
   input logic [VALUE_WIDTH-1:0]  req_r21,
   input logic [VALUE_WIDTH-1:0]  req_r22,
   input logic                    rsp_valid,
   input logic [VALUE_WIDTH-1:0]  rsp_quat_scalar,
   input logic [VALUE_WIDTH-1:0]  rsp_quat_x,
   input logic [VALUE_WIDTH-1:0]  rsp_quat_y,
   input logic [VALUE_WIDTH-1:0]  rsp_quat_z,
   input logic                    rsp_radicand_clamped
);

   localparam int W    = VALUE_WIDTH;
   localparam int LAT  = rmq_latency(VALUE_WIDTH, FRACTION_BITS);
   localparam int CW   = $clog2(LAT + 1);

   // Count cycles since reset, saturating at the pipeline depth
   logic [CW-1:0] since_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         since_ff <= '0;
      end else if (since_ff != CW'(LAT)) begin
         since_ff <= since_ff + 1'b1;
      end
   end

   logic                 beat;
   logic signed [W+1:0]  trace_w;

   assign beat     = start && !busy;
   assign trace_w  = (W+2)'($signed(req_r00)) + (W+2)'($signed(req_r11))
                   + (W+2)'($signed(req_r22));

   // Every accepted beat yields exactly one result after the fixed latency
   `RMQ_ASSERT_ALWAYS(a_latency, clock, reset, (since_ff != CW'(LAT)) || (rsp_valid == $past(beat, LAT)))

   // A clamp only comes from a negative-trace branch
   `RMQ_ASSERT_IMPLY(a_clamp_branch, clock, reset, rsp_valid && rsp_radicand_clamped, $past(trace_w[W+1], LAT))

   // The trace branch gives a non-negative scalar and never clamps
   `RMQ_ASSERT_IMPLY(a_trace_scalar, clock, reset, rsp_valid && !$past(trace_w[W+1], LAT), !rsp_quat_scalar[W-1] && !rsp_radicand_clamped)

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker #(
   .VALUE_WIDTH   (VALUE_WIDTH),
   .FRACTION_BITS (FRACTION_BITS)
) u_rmq_checker (.*);

// ----- tb/tb_rotation_matrix_to_quaternion_core.sv -----
// Self-checking bench for the rotation matrix to quaternion core: directed and random
// matrices, a bit-exact predictor of the trace method, and random start gaps.
// Depends on rmq_pkg and rotation_matrix_to_quaternion_core.
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion_core;
   import rmq_pkg::*;

   localparam int VW = VALUE_WIDTH_DEF;
   localparam int FB = FRACTION_BITS_DEF;
   localparam int LAT = rmq_latency(VW, FB);
   localparam int WATCHDOG_LIMIT = 20 * LAT + 2000;
   localparam logic signed [63:0] ONE = 64'sd1 <<< FB;
   localparam logic signed [63:0] QMAX = (64'sd1 <<< (VW - 1)) - 1;
   localparam logic signed [63:0] QMIN = -(64'sd1 <<< (VW - 1));

   typedef logic [VW-1:0] val_type;
   typedef struct {
      val_type m [9];
   } matrix_type;
   typedef struct {
      val_type q [4];
      logic clamped;
   } quat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   val_type req_r [9];
   logic rsp_valid;
   val_type rsp_quat_scalar, rsp_quat_x, rsp_quat_y, rsp_quat_z;
   logic rsp_radicand_clamped;

   matrix_type pending_matrices[$];
   quat_type   expected_quats[$];
   int      idle_pct = 0;
   bit      hold_sender = 1'b0;
   bit      failed = 1'b0;
   int      quiet_cycles = 0;

   always #5 clock = ~clock;

   initial foreach (req_r[i]) req_r[i] = '0;

   rotation_matrix_to_quaternion_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_r00(req_r[0]), .req_r01(req_r[1]), .req_r02(req_r[2]),
      .req_r10(req_r[3]), .req_r11(req_r[4]), .req_r12(req_r[5]),
      .req_r20(req_r[6]), .req_r21(req_r[7]), .req_r22(req_r[8]),
      .rsp_valid(rsp_valid), .rsp_quat_scalar(rsp_quat_scalar), .rsp_quat_x(rsp_quat_x),
      .rsp_quat_y(rsp_quat_y), .rsp_quat_z(rsp_quat_z),
      .rsp_radicand_clamped(rsp_radicand_clamped)
   );

   // Floor of the square root, bit by bit
   function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
      logic [63:0] root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // d * one / den, rounded half away from zero
   function automatic logic signed [63:0] round_quot(input logic signed [63:0] d,
                                                     input logic [63:0] den);
      logic [63:0] mag, q;
      mag = (d < 0) ? 64'(-d) : 64'(d);
      q = ((mag << FB) + den / 2) / den;
      return (d < 0) ? -$signed(q) : $signed(q);
   endfunction

   function automatic val_type saturate(input logic signed [63:0] v);
      if (v > QMAX) v = QMAX;
      if (v < QMIN) v = QMIN;
      return v[VW-1:0];
   endfunction

   // Trace method quaternion of one matrix
   function automatic quat_type matrix_to_quat(input matrix_type mx);
      logic signed [63:0] e [9];
      logic signed [63:0] trace, rad;
      logic signed [63:0] d [3];
      logic signed [63:0] comp [4];
      logic [63:0] half;
      sel_type sel;
      quat_type res;
      foreach (e[i]) e[i] = 64'($signed(mx.m[i]));
      trace = e[0] + e[4] + e[8];
      res.clamped = 1'b0;
      if (trace >= 0) begin
         sel = SEL_TRACE;
         rad = trace + ONE;
         d[0] = e[7] - e[5]; d[1] = e[2] - e[6]; d[2] = e[3] - e[1];
      end else begin
         sel = SEL_X;
         if (e[4] > e[0]) sel = SEL_Y;
         if (e[8] > ((sel == SEL_Y) ? e[4] : e[0])) sel = SEL_Z;
         case (sel)
            SEL_X: begin
               rad = e[0] - (e[4] + e[8]) + ONE;
               d[0] = e[1] + e[3]; d[1] = e[2] + e[6]; d[2] = e[7] - e[5];
            end
            SEL_Y: begin
               rad = e[4] - (e[8] + e[0]) + ONE;
               d[0] = e[1] + e[3]; d[1] = e[5] + e[7]; d[2] = e[2] - e[6];
            end
            default: begin
               rad = e[8] - (e[0] + e[4]) + ONE;
               d[0] = e[2] + e[6]; d[1] = e[5] + e[7]; d[2] = e[3] - e[1];
            end
         endcase
      end
      if (rad <= 0) begin
         rad = 1;
         res.clamped = 1'b1;
      end
      half = floor_sqrt(64'(rad) << (FB - 2));
      case (sel)
         SEL_TRACE: begin
            comp[0] = half;
            for (int i = 0; i < 3; i++) comp[i+1] = round_quot(d[i], half * 4);
         end
         SEL_X: begin
            comp[1] = half; comp[2] = round_quot(d[0], half * 4);
            comp[3] = round_quot(d[1], half * 4); comp[0] = round_quot(d[2], half * 4);
         end
         SEL_Y: begin
            comp[2] = half; comp[1] = round_quot(d[0], half * 4);
            comp[3] = round_quot(d[1], half * 4); comp[0] = round_quot(d[2], half * 4);
         end
         default: begin
            comp[3] = half; comp[1] = round_quot(d[0], half * 4);
            comp[2] = round_quot(d[1], half * 4); comp[0] = round_quot(d[2], half * 4);
         end
      endcase
      foreach (comp[i]) res.q[i] = saturate(comp[i]);
      return res;
   endfunction

   function automatic val_type fx(input real v);
      return val_type'($rtoi(v * real'(ONE)));
   endfunction

   function automatic matrix_type make_matrix(input real a0, a1, a2, a3, a4, a5, a6, a7, a8);
      matrix_type mx;
      mx.m = '{fx(a0), fx(a1), fx(a2), fx(a3), fx(a4), fx(a5), fx(a6), fx(a7), fx(a8)};
      return mx;
   endfunction

   // Proper rotation built from a random unit quaternion
   function automatic matrix_type random_rotation();
      real w, x, y, z, n;
      w = real'($urandom_range(2000)) - 1000.0;
      x = real'($urandom_range(2000)) - 1000.0;
      y = real'($urandom_range(2000)) - 1000.0;
      z = real'($urandom_range(2000)) - 1000.0;
      n = $sqrt(w*w + x*x + y*y + z*z) + 1.0e-9;
      w /= n; x /= n; y /= n; z /= n;
      return make_matrix(1 - 2*(y*y + z*z), 2*(x*y - z*w), 2*(x*z + y*w),
                         2*(x*y + z*w), 1 - 2*(x*x + z*z), 2*(y*z - x*w),
                         2*(x*z - y*w), 2*(y*z + x*w), 1 - 2*(x*x + y*y));
   endfunction

   function automatic matrix_type random_raw();
      matrix_type mx;
      foreach (mx.m[i]) mx.m[i] = val_type'($urandom);
      return mx;
   endfunction

   // Drive the next beat, or idle at the current rate
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (pending_matrices.size() != 0 && !hold_sender &&
             $urandom_range(99) >= idle_pct) begin
            matrix_type mx;
            mx = pending_matrices.pop_front();
            foreach (req_r[i]) req_r[i] <= mx.m[i];
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Predict at acceptance, compare each strobed result with the oldest prediction
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (start && !busy) begin
            matrix_type mx;
            foreach (mx.m[i]) mx.m[i] = req_r[i];
            expected_quats.push_back(matrix_to_quat(mx));
         end
         if (rsp_valid) begin
            if (expected_quats.size() == 0) begin
               $display("%0t: unexpected result scalar=%h", $time, rsp_quat_scalar);
               failed = 1'b1;
            end else begin
               quat_type want;
               val_type got [4];
               want = expected_quats.pop_front();
               got = '{rsp_quat_scalar, rsp_quat_x, rsp_quat_y, rsp_quat_z};
               foreach (got[i])
                  if (got[i] !== want.q[i]) begin
                     $display("%0t: component %0d expected %h actual %h",
                              $time, i, want.q[i], got[i]);
                     failed = 1'b1;
                  end
               if (rsp_radicand_clamped !== want.clamped) begin
                  $display("%0t: clamped expected %b actual %b",
                           $time, want.clamped, rsp_radicand_clamped);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   // Stop the run when nothing moves for too long
   always @(posedge clock) begin
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** rotation_matrix_to_quaternion_core: FAILED **");
         $finish;
      end
   end

   task automatic drain_queue();
      while (pending_matrices.size() != 0 || expected_quats.size() != 0 || start)
         @(posedge clock);
   endtask

   initial begin
      matrix_type mx;
      int phase_rates [4] = '{0, 68, 0, 27};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: identity, half turns, ties, extremes, a zero matrix
      pending_matrices.push_back(make_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
      pending_matrices.push_back(make_matrix(1, 0, 0, 0, -1, 0, 0, 0, -1));
      pending_matrices.push_back(make_matrix(-1, 0, 0, 0, 1, 0, 0, 0, -1));
      pending_matrices.push_back(make_matrix(-1, 0, 0, 0, -1, 0, 0, 0, 1));
      pending_matrices.push_back(make_matrix(-0.5, 0, 0, 0, -0.5, 0, 0, 0, -0.5));
      pending_matrices.push_back(make_matrix(-0.5, 0, 0, 0, -0.5, 0, 0, 0, -0.75));
      pending_matrices.push_back(make_matrix(-0.75, 0, 0, 0, -0.5, 0, 0, 0, -0.5));
      pending_matrices.push_back(make_matrix(0, -1, 0, 1, 0, 0, 0, 0, 1));
      pending_matrices.push_back(make_matrix(0, 0, 1, 0, 1, 0, -1, 0, 0));
      foreach (mx.m[i]) mx.m[i] = {1'b1, {(VW-1){1'b0}}};
      pending_matrices.push_back(mx);
      foreach (mx.m[i]) mx.m[i] = {1'b0, {(VW-1){1'b1}}};
      pending_matrices.push_back(mx);
      mx.m = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
               16'h8000, 16'h7fff, 16'h8000};
      pending_matrices.push_back(mx);
      mx.m = '{16'h8000, 16'h7fff, 16'h0001, 16'h8000, 16'h7fff, 16'h8000,
               16'h7fff, 16'h8000, 16'h7fff};
      pending_matrices.push_back(mx);
      pending_matrices.push_back(make_matrix(-1.9, 1.9, -1.9, 1.9, -1.9, 1.9, -1.9, 1.9, -1.9));
      pending_matrices.push_back(make_matrix(-1, 0, 0, 0, 0, -1, 0, -1, 0));
      pending_matrices.push_back(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
      drain_queue();

      // Random phases: mostly rotations, some raw noise
      foreach (phase_rates[p]) begin
         idle_pct = phase_rates[p];
         repeat (125) begin
            if ($urandom_range(99) < 75) pending_matrices.push_back(random_rotation());
            else pending_matrices.push_back(random_raw());
         end
         if (p == 1) begin
            // Hold the sender until every outstanding result has come back
            wait (pending_matrices.size() < 60);
            hold_sender = 1'b1;
            while (expected_quats.size() != 0) @(posedge clock);
            hold_sender = 1'b0;
         end
         drain_queue();
      end

      repeat (LAT + 10) @(posedge clock);
      if (!failed && expected_quats.size() == 0)
         $display("** rotation_matrix_to_quaternion_core: PASSED **");
      else
         $display("** rotation_matrix_to_quaternion_core: FAILED **");
      $finish;
   end

endmodule
